[rtl/rbd_pkg.sv]
// Shared types and constants for the RGBA 2x2 box downsampler.
// Request and response payload structs, control struct, register indexes.
// No dependencies.
package rbd_pkg;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 13;
   localparam int unsigned ROW_W      = 12;
   localparam int unsigned MAX_ROWS   = 4096;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned PAIR_W     = 9;
   localparam int unsigned SUM_W      = 10;
   localparam int unsigned ENTRY_W    = 4 * SUM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 1'd1;

   typedef struct packed {
      logic [CHAN_W-1:0] pix_alpha;
      logic [CHAN_W-1:0] pix_blue;
      logic [CHAN_W-1:0] pix_green;
      logic [CHAN_W-1:0] pix_red;
   } rbd_req_type;

   typedef struct packed {
      logic              frame_last;
      logic [CHAN_W-1:0] out_alpha;
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
   } rbd_rsp_type;

   typedef struct packed {
      logic left_load;
      logic dup_col;
      logic dup_row;
      logic wr_en;
      logic rd_en;
      logic emit;
      logic last;
   } rbd_ctrl_type;

endpackage

[rtl/rbd_line_mem.sv]
// Line store of horizontal pair sums, one entry per output column.
// Single write port, single read port with registered read data.
// Depends on nothing outside this file.
module rbd_line_mem #(
   parameter int unsigned DEPTH = 2048,
   parameter int unsigned AW    = 11,
   parameter int unsigned DW    = 40
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rbd_sequencer.sv]
// Frame sequencer: size registers, column and row counters, per-pixel decisions.
// Uses rbd_pkg for the control struct and register indexes.
module rbd_sequencer
   import rbd_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 4096,
   parameter int unsigned AW        = 11,
   parameter int unsigned XW        = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_accept,
   output rbd_ctrl_type          ctrl,
   output logic [AW-1:0]         line_addr
);

   logic [XW-1:0]    wm1_ff, wm1_in;
   logic [AW-1:0]    owm1_ff, owm1_in;
   logic             w1_ff, w1_in;
   logic [ROW_W-1:0] hm1_ff, hm1_in;
   logic [ROW_W-2:0] ohm1_ff, ohm1_in;
   logic             h1_ff, h1_in;
   logic             hodd_ff, hodd_in;
   logic [XW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [XW:0]      w_clamp;
   logic [ROW_W:0]   h_clamp;
   logic             x_last, y_last, have_pair, keep_even;
   logic [AW-1:0]    ox;
   logic [ROW_W-2:0] oy;

   always_comb begin
      w_clamp = (XW+1)'(csr_wdata);
      if (csr_wdata == '0) begin
         w_clamp = (XW+1)'(1);
      end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
         w_clamp = (XW+1)'(MAX_WIDTH);
      end
      h_clamp = (ROW_W+1)'(csr_wdata);
      if (csr_wdata == '0) begin
         h_clamp = (ROW_W+1)'(1);
      end else if (32'(csr_wdata) > 32'(MAX_ROWS)) begin
         h_clamp = (ROW_W+1)'(MAX_ROWS);
      end
   end

   always_comb begin
      wm1_in  = wm1_ff;
      owm1_in = owm1_ff;
      w1_in   = w1_ff;
      hm1_in  = hm1_ff;
      ohm1_in = ohm1_ff;
      h1_in   = h1_ff;
      hodd_in = hodd_ff;
      if (csr_we && csr_index == CSR_SRC_WIDTH) begin
         wm1_in  = XW'(w_clamp - 1'b1);
         w1_in   = (w_clamp == (XW+1)'(1));
         owm1_in = (w_clamp == (XW+1)'(1)) ? '0 : AW'((w_clamp >> 1) - 1'b1);
      end
      if (csr_we && csr_index == CSR_SRC_HEIGHT) begin
         hm1_in  = ROW_W'(h_clamp - 1'b1);
         h1_in   = (h_clamp == (ROW_W+1)'(1));
         hodd_in = h_clamp[0];
         ohm1_in = (h_clamp == (ROW_W+1)'(1)) ? '0 : (ROW_W-1)'((h_clamp >> 1) - 1'b1);
      end
   end

   assign x_last    = (col_ff == wm1_ff);
   assign y_last    = (row_ff == hm1_ff);
   assign have_pair = w1_ff | col_ff[0];
   assign keep_even = !(hodd_ff && y_last);
   assign ox        = w1_ff ? '0 : col_ff[AW:1];
   assign oy        = h1_ff ? '0 : row_ff[ROW_W-1:1];

   always_comb begin
      ctrl.left_load = !w1_ff && !col_ff[0];
      ctrl.dup_col   = w1_ff;
      ctrl.dup_row   = h1_ff;
      ctrl.wr_en     = have_pair && !h1_ff && !row_ff[0] && keep_even;
      ctrl.rd_en     = have_pair && !h1_ff && row_ff[0];
      ctrl.emit      = have_pair && (h1_ff || row_ff[0]);
      ctrl.last      = (ox == owm1_ff) && (oy == ohm1_ff);
   end

   assign line_addr = ox;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (x_last) begin
            col_in = '0;
            row_in = y_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff  <= '0;
         owm1_ff <= '0;
         w1_ff   <= 1'b1;
         hm1_ff  <= '0;
         ohm1_ff <= '0;
         h1_ff   <= 1'b1;
         hodd_ff <= 1'b1;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         wm1_ff  <= wm1_in;
         owm1_ff <= owm1_in;
         w1_ff   <= w1_in;
         hm1_ff  <= hm1_in;
         ohm1_ff <= ohm1_in;
         h1_ff   <= h1_in;
         hodd_ff <= hodd_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

[rtl/rgba_box_downsample_2x2.sv]
// RGBA8 2x2 box downsampler, one source pixel per request and at most one
// output pixel per request. Takes one request per clock unless stage one
// holds a pixel while the output register waits on a stalled response; a
// pixel completing a 2x2 block goes through stage one, then the output
// register. The line store does at most one write (even rows) or one read
// (odd rows) per pixel, allowing one pixel per clock. Writing a size register
// restarts the frame. Depends on rbd_pkg, rbd_sequencer and rbd_line_mem.
module rgba_box_downsample_2x2
   import rbd_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rbd_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rbd_rsp_type           rsp_payload
);

   localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
   localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int unsigned XW = ($clog2(MAX_WIDTH) > AW) ? $clog2(MAX_WIDTH) : AW + 1;

   rbd_ctrl_type ctrl;
   logic [AW-1:0] line_addr;
   logic req_accept, out_free;

   logic [3:0][CHAN_W-1:0] pix, left_ff, left_in;
   logic [3:0][PAIR_W-1:0] pair;
   logic [3:0][PAIR_W-1:0] s1_pair_ff;
   logic [ENTRY_W-1:0]     wr_entry, rd_entry;
   logic [3:0][SUM_W-1:0]  sum;
   logic s1_valid_ff, s1_valid_in;
   logic s1_dup_row_ff, s1_last_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rbd_rsp_type rsp_payload_ff, rsp_payload_in;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   rbd_sequencer #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW),
      .XW        (XW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_accept (req_accept),
      .ctrl       (ctrl),
      .line_addr  (line_addr)
   );

   assign pix = {req_payload.pix_alpha, req_payload.pix_blue,
                 req_payload.pix_green, req_payload.pix_red};

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         pair[c] = ctrl.dup_col ? {pix[c], 1'b0}
                                : PAIR_W'(left_ff[c]) + PAIR_W'(pix[c]);
         wr_entry[c*SUM_W +: SUM_W] = SUM_W'(pair[c]);
      end
      left_in = (req_accept && ctrl.left_load) ? pix : left_ff;
   end

   rbd_line_mem #(
      .DEPTH (LINE_DEPTH),
      .AW    (AW),
      .DW    (ENTRY_W)
   ) u_line (
      .clock   (clock),
      .wr_en   (req_accept && ctrl.wr_en),
      .wr_addr (line_addr),
      .wr_data (wr_entry),
      .rd_en   (req_accept && ctrl.rd_en),
      .rd_addr (line_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum[c] = s1_dup_row_ff ? {s1_pair_ff[c], 1'b0}
                                : rd_entry[c*SUM_W +: SUM_W] + SUM_W'(s1_pair_ff[c]);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = ctrl.emit;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (out_free) begin
         rsp_valid_in              = s1_valid_ff;
         rsp_payload_in.out_red    = sum[0][SUM_W-1:2];
         rsp_payload_in.out_green  = sum[1][SUM_W-1:2];
         rsp_payload_in.out_blue   = sum[2][SUM_W-1:2];
         rsp_payload_in.out_alpha  = sum[3][SUM_W-1:2];
         rsp_payload_in.frame_last = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff        <= left_in;
      rsp_payload_ff <= rsp_payload_in;
      if (req_accept) begin
         s1_pair_ff    <= pair;
         s1_dup_row_ff <= ctrl.dup_row;
         s1_last_ff    <= ctrl.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_no_rd_wr_same: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !(ctrl.wr_en && ctrl.rd_en))
      else $error("line store read and write on one request");

   a_emit_to_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept && ctrl.emit |=> s1_valid_ff)
      else $error("emitting request did not reach stage one");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_pair_ff))
      else $error("stage one lost its pixel while the output was stalled");

   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_free |=> rsp_valid)
      else $error("stage one pixel did not reach the output register");

endmodule

[tb/sv/rgba_box_downsample_2x2_tb.sv]
// Self-checking testbench for the RGBA 2x2 box downsampler.
// Streams pixels under several frame sizes, predicts each output pixel and compares it.
// Depends on rbd_pkg and rgba_box_downsample_2x2.
module rgba_box_downsample_2x2_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rbd_pkg::*;

   localparam int unsigned MAX_COLS       = 4096;
   localparam int unsigned LINE_DEPTH     = MAX_COLS / 2;
   localparam int unsigned DRAIN_CYCLES   = 4;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   rbd_req_type           req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rbd_rsp_type           rsp_payload;

   logic [CSR_DATA_W-1:0]   width_reg  = 1;
   logic [CSR_DATA_W-1:0]   height_reg = 1;
   int unsigned             col_pos    = 0;
   int unsigned             row_pos    = 0;
   logic [3:0][CHAN_W-1:0]  left_pix   = '0;
   logic [3:0][SUM_W-1:0]   pair_line [LINE_DEPTH];

   rbd_rsp_type  pixel_q [$];
   bit           pred_emit;
   rbd_rsp_type  pred_pixel;
   rbd_rsp_type  want_pixel;
   bit           no_idle      = 1'b0;
   int unsigned  errors       = 0;
   int unsigned  pixels_sent  = 0;
   int unsigned  pixels_out   = 0;
   int unsigned  size_writes  = 0;
   int unsigned  quiet_cycles = 0;

   rgba_box_downsample_2x2 DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                             input int unsigned top);
      if (v == 0)
         return 1;
      return (v > top) ? top : int'(v);
   endfunction

   function automatic void predict_pixel(input rbd_req_type p, output bit emit,
                                         output rbd_rsp_type px);
      int unsigned w, h, ow, oh, ox, oy;
      int c;
      logic [3:0][CHAN_W-1:0] cur;
      logic [3:0][SUM_W-1:0]  pair, sum;
      bit have_pair;
      w = clamp_dim(width_reg, MAX_COLS);
      h = clamp_dim(height_reg, MAX_ROWS);
      ow = (w / 2 != 0) ? w / 2 : 1;
      oh = (h / 2 != 0) ? h / 2 : 1;
      cur = {p.pix_alpha, p.pix_blue, p.pix_green, p.pix_red};
      pair = '0;
      sum = '0;
      have_pair = 1'b0;
      emit = 1'b0;
      px = '0;
      ox = 0;
      if (w == 1) begin
         for (c = 0; c < 4; c++)
            pair[c] = SUM_W'(cur[c]) << 1;
         have_pair = 1'b1;
      end else begin
         ox = col_pos / 2;
         if (col_pos % 2 == 0) begin
            left_pix = cur;
         end else if (col_pos < 2 * ow) begin
            for (c = 0; c < 4; c++)
               pair[c] = SUM_W'(left_pix[c]) + SUM_W'(cur[c]);
            have_pair = 1'b1;
         end
      end
      oy = (h == 1) ? 0 : row_pos / 2;
      if (have_pair && ox < LINE_DEPTH) begin
         if (h == 1) begin
            for (c = 0; c < 4; c++)
               sum[c] = pair[c] << 1;
            emit = 1'b1;
         end else if (row_pos % 2 == 0) begin
            if (row_pos < 2 * oh)
               pair_line[ox] = pair;
         end else begin
            for (c = 0; c < 4; c++)
               sum[c] = pair_line[ox][c] + pair[c];
            emit = 1'b1;
         end
      end
      if (emit) begin
         px.out_red    = sum[0][SUM_W-1:2];
         px.out_green  = sum[1][SUM_W-1:2];
         px.out_blue   = sum[2][SUM_W-1:2];
         px.out_alpha  = sum[3][SUM_W-1:2];
         px.frame_last = (ox == ow - 1) && (oy == oh - 1);
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h)
            row_pos = 0;
      end
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_pixel(req_payload, pred_emit, pred_pixel);
            if (pred_emit)
               pixel_q = {pixel_q, pred_pixel};
         end
         if (rsp_valid && !rsp_stall) begin
            pixels_out++;
            if (pixel_q.size() == 0) begin
               $error("unexpected output pixel %h", rsp_payload);
               errors++;
            end else begin
               want_pixel = pixel_q.pop_front();
               check_field("out_red", want_pixel.out_red, rsp_payload.out_red);
               check_field("out_green", want_pixel.out_green, rsp_payload.out_green);
               check_field("out_blue", want_pixel.out_blue, rsp_payload.out_blue);
               check_field("out_alpha", want_pixel.out_alpha, rsp_payload.out_alpha);
               check_field("frame_last", 8'(want_pixel.frame_last),
                           8'(rsp_payload.frame_last));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Timeout: no request or response for %0d cycles", quiet_cycles);
               $display("FAIL rgba_box_downsample_2x2");
               $finish;
            end
         end
      end
   end

   task automatic send_pixel(input rbd_req_type pix);
      while (!no_idle && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= pix;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pixels_sent++;
   endtask

   task automatic send_frame(input int unsigned count);
      repeat (count)
         send_pixel(rbd_req_type'($urandom));
   endtask

   // drain all pending output pixels before touching a size register
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SRC_WIDTH)
         width_reg = CSR_DATA_W'(value);
      else
         height_reg = CSR_DATA_W'(value);
      col_pos = 0;
      row_pos = 0;
      size_writes++;
      @(posedge clock);
   endtask

   task automatic set_size(input int unsigned w, input int unsigned h);
      settle();
      write_size(CSR_SRC_WIDTH, w);
      write_size(CSR_SRC_HEIGHT, h);
   endtask

   task automatic test_single_pixel_frames();
      send_pixel('0);
      send_pixel('1);
      send_pixel(32'h80FF_017F);
      set_size(0, 0);
      send_frame(2);
   endtask

   task automatic test_small_frames();
      set_size(2, 2);
      send_frame(8);
      set_size(3, 3);
      send_frame(9);
      set_size(1, 4);
      send_frame(4);
      set_size(4, 1);
      send_frame(4);
   endtask

   task automatic test_restart();
      set_size(4, 4);
      send_frame(5);
      settle();
      write_size(CSR_SRC_WIDTH, 4);
      send_frame(16);
   endtask

   task automatic test_size_limits();
      set_size(8191, 1);
      send_frame(64);
      set_size(1, 8191);
      send_frame(32);
      set_size(2, 8191);
      send_frame(16);
   endtask

   task automatic test_random_frames(input int unsigned target);
      int unsigned start, done, w, h, k, len, n;
      start = pixels_sent;
      done = 0;
      while (done < target) begin
         no_idle = (done >= target / 3) && (done < target / 2);
         k = $urandom_range(99);
         if (k < 10) begin
            w = $urandom_range(13, 40);
            h = $urandom_range(0, 4);
         end else if (k < 20) begin
            w = $urandom_range(0, 4);
            h = $urandom_range(9, 24);
         end else begin
            w = $urandom_range(0, 12);
            h = $urandom_range(0, 8);
         end
         settle();
         if ($urandom_range(3) != 0)
            write_size(CSR_SRC_WIDTH, w);
         if ($urandom_range(3) != 0)
            write_size(CSR_SRC_HEIGHT, h);
         len = clamp_dim(width_reg, MAX_COLS) * clamp_dim(height_reg, MAX_ROWS);
         repeat ($urandom_range(1, 3)) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1, len) : len;
            if (pixels_sent - start < target)
               send_frame(n);
         end
         done = pixels_sent - start;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset       <= 1'b1;
      csr_we      <= 1'b0;
      csr_index   <= CSR_SRC_WIDTH;
      csr_wdata   <= '0;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_pixel_frames();
      test_small_frames();
      test_restart();
      test_size_limits();
      test_random_frames(590);
      settle();
      $display("Sent %0d source pixels across %0d size register writes,", pixels_sent,
               size_writes);
      $display("including clamped, single-line and odd sizes; checked %0d output pixels.",
               pixels_out);
      if (errors == 0)
         $display("PASS rgba_box_downsample_2x2");
      else
         $display("FAIL rgba_box_downsample_2x2");
      $finish;
   end

endmodule

[files.f]
rtl/rbd_pkg.sv
rtl/rbd_line_mem.sv
rtl/rbd_sequencer.sv
rtl/rgba_box_downsample_2x2.sv
tb/sv/rgba_box_downsample_2x2_tb.sv
